>>> src/sb2dec_pkg.sv
// ----------------------------------------------------------------------------
// sb2dec_pkg
// Shared constants and controller/datapath interface types for the signed
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sb2dec_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic put_sign;
        logic put_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic more;
        logic neg;
        logic out_free;
    } t_sts;

endpackage

>>> src/sb2dec_ctrl.sv
// ----------------------------------------------------------------------------
// sb2dec_ctrl
// Sequencer: load, 64 double-dabble steps, leading-zero skip, then sign and
// digit emission into the output register.
// ----------------------------------------------------------------------------
module sb2dec_ctrl
    import sb2dec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_sts.top_zero && i_sts.more) begin
                    o_cmd.shift = 1'b1;
                end else if (i_sts.neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.put_sign = 1'b1;
                    n_state        = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.put_digit = 1'b1;
                    if (!i_sts.more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> src/sb2dec_dp.sv
// ----------------------------------------------------------------------------
// sb2dec_dp
// Datapath: magnitude shift register, 20-digit BCD register with add-3
// correction, digit countdown and the output word register.
// ----------------------------------------------------------------------------
module sb2dec_dp
    import sb2dec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_cmd                      i_cmd,
    input  logic                      i_stall,
    output t_sts                      o_sts,
    output logic                      o_valid,
    output logic [CHAR_W-1:0]         o_char_code,
    output logic                      o_is_last
);

    logic [VALUE_W-1:0] r_mag;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd_adj;
    logic [STEP_W-1:0]  r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic               r_neg;
    logic               r_o_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [DIGIT_W-1:0] top_digit;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_bcd[k*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
                n_bcd_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                n_bcd_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_W-1];
            r_mag <= i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
            r_bcd <= '0;
            r_cnt <= '0;
            r_rem <= REM_W'(NUM_DIGITS);
        end else if (i_cmd.step) begin
            r_bcd <= {n_bcd_adj[BCD_W-2:0], r_mag[VALUE_W-1]};
            r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + STEP_W'(1);
        end else if (i_cmd.shift || i_cmd.put_digit) begin
            r_bcd <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_rem <= r_rem - REM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_char <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
            r_last <= (r_rem == REM_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.put_sign || i_cmd.put_digit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.conv_done = (r_cnt == {STEP_W{1'b1}});
    assign o_sts.top_zero  = (top_digit == '0);
    assign o_sts.more      = (r_rem != REM_W'(1));
    assign o_sts.neg       = r_neg;
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

>>> src/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 64-bit integer to its decimal ASCII text, one character
// per output word, most significant first, with a minus sign when negative.
//
//   channel | direction | valid   | stall   | payload
//   --------+-----------+---------+---------+-------------------------
//   input   | in        | i_valid | o_stall | i_value[63:0]
//   output  | out       | o_valid | i_stall | o_char_code[7:0], o_is_last
//
// One number takes a load, 64 shift-add-3 steps, a skip over the leading zero
// digits of an N-digit result and the exit from that skip, then one output
// character per cycle while the output does not stall (N, plus one for the
// sign when the number is negative).
// A new number is taken while the last character still waits in the output
// register. Reset is synchronous, active low, and clears the sequencer and
// the output valid. Output stalls hold the current word and pause emission.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sb2dec_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [CHAR_W-1:0]         o_char_code,
    output logic                      o_is_last
);

    t_cmd cmd;
    t_sts sts;
    logic busy;

    sb2dec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    sb2dec_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .i_stall     (i_stall),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    assign o_stall = busy;

endmodule

>>> src/sb2dec_checker.sv
// ----------------------------------------------------------------------------
// sb2dec_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sb2dec_checker
    import sb2dec_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic signed [VALUE_W-1:0] i_value,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [CHAR_W-1:0]         o_char_code,
    input logic                      o_is_last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code) && $stable(o_is_last))
        else $error("output word changed under stall");

    // one number at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while conversion in progress");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS) ||
                    (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_ZERO + 8'd9))
        else $error("illegal character code");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CHAR_MINUS) |-> !o_is_last)
        else $error("minus sign marked last");

endmodule

bind signed_binary_to_decimal_ascii sb2dec_checker u_sb2dec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_value     (i_value),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_char_code (o_char_code),
    .o_is_last   (o_is_last)
);
